@@ rtl/core/flcl_pkg.sv @@
// ----------------------------------------------------------------------------
// flcl_pkg
// Shared types and constants for the fixed-capacity ordered list.
// ----------------------------------------------------------------------------
package flcl_pkg;

  localparam int unsigned DEF_MAX_ENTRIES   = 16;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [POS_W-1:0]   NO_INDEX    = 5'h1F;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_GET      = 2'd2,
    KIND_INDEX_OF = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch request, clear scan pointer
    logic step;   // advance search pointer
    logic emit;   // commit update and capture result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search; // request is an index_of
    logic hit;    // search ends here (match or end of list)
  } sts_t;

endpackage

@@ rtl/core/fixed_capacity_ordered_list.sv @@
// ----------------------------------------------------------------------------
// fixed_capacity_ordered_list
// Ordered list of element words with insert, remove, get and index_of,
// bounded by a programmable capacity limit.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// request   in         start_i & !busy_o          kind_i position_i element_i
// result    out        done_o (one cycle)         ok_o read_word_o found_index_o
//                                                 count_o is_empty_o
// config    in         capacity_limit_we_i        capacity_limit_i
//
// Insert, remove and get pass once through the exec state between accept and done; done coincides
// with busy dropping, so the next request may be taken in the done cycle.
// index_of walks the entries through the single read port, one per cycle,
// until it reaches the matching index or the count when nothing matches.
// Reset empties the list and sets the limit to 16; no clearing pass.
// The receiver cannot stall; done is high for a single cycle and the results hold until the next request completes.
// ----------------------------------------------------------------------------
module fixed_capacity_ordered_list
  import flcl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  logic                     capacity_limit_we_i,
  input  logic [LIMIT_W-1:0]       capacity_limit_i,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic [ELEM_W-1:0]        element_i,
  output logic                     ok_o,
  output logic [ELEM_W-1:0]        read_word_o,
  output logic signed [POS_W-1:0]  found_index_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_empty_o
);

  cmd_t             cmd;
  sts_t             sts;
  logic             busy;
  logic [POS_W-1:0] found;

  flcl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  flcl_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .limit_we_i    (capacity_limit_we_i),
    .limit_i       (capacity_limit_i),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .element_i     (element_i),
    .ok_o          (ok_o),
    .read_word_o   (read_word_o),
    .found_index_o (found),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o)
  );

  assign busy_o        = busy;
  assign found_index_o = signed'(found);

endmodule

@@ rtl/core/flcl_ctrl.sv @@
// ----------------------------------------------------------------------------
// flcl_ctrl
// Request sequencer: accepts a request, runs the search walk when needed,
// and strobes done for one cycle as the result is captured.
// ----------------------------------------------------------------------------
module flcl_ctrl
  import flcl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.search || sts_i.hit) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

@@ rtl/core/flcl_datapath.sv @@
// ----------------------------------------------------------------------------
// flcl_datapath
// Entry cells with in-place shift for insert/remove, one shared read port
// for get and the search walk, capacity register and result registers.
// ----------------------------------------------------------------------------
module flcl_datapath
  import flcl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               limit_we_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [ELEM_W-1:0]  element_i,
  output logic               ok_o,
  output logic [ELEM_W-1:0]  read_word_o,
  output logic [POS_W-1:0]   found_index_o,
  output logic [CNT_W-1:0]   count_o,
  output logic               is_empty_o
);

  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  logic [ELEMENT_WIDTH-1:0] entries_q [MAX_ENTRIES];
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            scan_q;
  logic [LIMIT_W-1:0]       limit_q;
  kind_e                    kind_q;
  logic [POS_W-1:0]         pos_q;
  logic [ELEMENT_WIDTH-1:0] word_q;

  logic                     ok_q;
  logic [ELEM_W-1:0]        rd_q;
  logic [POS_W-1:0]         found_q;
  logic [CNT_W-1:0]         cnt_out_q;
  logic                     empty_q;

  logic [63:0]              elem_ext;
  logic [63:0]              rd_ext;
  logic [CMPW-1:0]          pos_x, cnt_x, lim_x;
  logic [IW-1:0]            rd_idx;
  logic [ELEMENT_WIDTH-1:0] rd_word;
  logic                     ins_ok, in_range, scan_end, match;
  logic                     do_ins, do_rem;
  logic                     ok_d;
  logic [ELEM_W-1:0]        rd_d;
  logic [POS_W-1:0]         found_d;

  assign elem_ext = 64'(element_i);
  assign pos_x    = CMPW'(pos_q);
  assign cnt_x    = CMPW'(count_q);
  assign lim_x    = CMPW'(limit_q);

  assign ins_ok   = (cnt_x < lim_x) && (cnt_x < CMPW'(MAX_ENTRIES)) && (pos_x <= cnt_x);
  assign in_range = (pos_x < cnt_x);
  assign scan_end = (scan_q >= count_q);

  assign rd_idx   = (kind_q == KIND_INDEX_OF) ? scan_q[IW-1:0] : pos_x[IW-1:0];
  assign rd_word  = entries_q[rd_idx];
  assign rd_ext   = 64'(rd_word);
  assign match    = (rd_word == word_q);

  assign sts_o.search = (kind_q == KIND_INDEX_OF);
  assign sts_o.hit    = scan_end || match;

  assign do_ins = cmd_i.emit && (kind_q == KIND_INSERT) && ins_ok;
  assign do_rem = cmd_i.emit && (kind_q == KIND_REMOVE) && in_range;

  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    rd_d    = '0;
    found_d = NO_INDEX;
    case (kind_q)
      KIND_INSERT: begin
        ok_d = ins_ok;
        if (ins_ok) count_d = count_q + CW'(1);
      end
      KIND_REMOVE: begin
        ok_d = in_range;
        if (in_range) count_d = count_q - CW'(1);
      end
      KIND_GET: begin
        ok_d = in_range;
        if (in_range) rd_d = rd_ext[ELEM_W-1:0];
      end
      default: begin
        ok_d = !scan_end && match;
        if (!scan_end && match) found_d = POS_W'(scan_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LIMIT_RESET;
      scan_q  <= '0;
    end else begin
      if (limit_we_i) limit_q <= limit_i;
      if (cmd_i.emit) count_q <= count_d;
      if (cmd_i.load) scan_q <= '0;
      else if (cmd_i.step) scan_q <= scan_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(kind_i);
      pos_q  <= position_i;
      word_q <= elem_ext[ELEMENT_WIDTH-1:0];
    end
    if (cmd_i.emit) begin
      ok_q      <= ok_d;
      rd_q      <= rd_d;
      found_q   <= found_d;
      cnt_out_q <= CNT_W'(count_d);
      empty_q   <= (count_d == '0);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (do_ins) begin
        if (CMPW'(i) == pos_x) begin
          entries_q[i] <= word_q;
        end else if (i > 0 && CMPW'(i) > pos_x && CMPW'(i) <= cnt_x) begin
          entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if (i + 1 < MAX_ENTRIES && CMPW'(i) >= pos_x && CMPW'(i + 1) < cnt_x) begin
          entries_q[i] <= entries_q[(i + 1 < MAX_ENTRIES) ? i + 1 : i];
        end
      end
    end
  end

  assign ok_o          = ok_q;
  assign read_word_o   = rd_q;
  assign found_index_o = found_q;
  assign count_o       = cnt_out_q;
  assign is_empty_o    = empty_q;

endmodule
